// ===== sv/cfd_pkg.sv =====
// ---------------------------------------------------------------------------
// cfd_pkg: shared types and constants for capture_frequency_discipline
// Field widths, status codes, register indexes and the controller/datapath
// command and status bundles.
// ---------------------------------------------------------------------------
package cfd_pkg;

	localparam int CNT_W  = 16;   // capture counter width
	localparam int FREQ_W = 32;   // tuning word width
	localparam int CFG_W  = 32;   // config data width
	localparam int IDX_W  = 2;    // config register index width
	localparam int STS_W  = 2;    // result status width

	// Result status codes
	localparam logic [STS_W-1:0] ST_PRIMED = 2'd0;
	localparam logic [STS_W-1:0] ST_REJECT = 2'd1;
	localparam logic [STS_W-1:0] ST_UPDATE = 2'd2;

	// Config register indexes
	localparam logic [IDX_W-1:0] REG_START = 2'd0;
	localparam logic [IDX_W-1:0] REG_HIGH  = 2'd1;
	localparam logic [IDX_W-1:0] REG_LOW   = 2'd2;

	// Controller to datapath
	typedef struct packed {
		logic             load;       // capture word accepted
		logic             mul_first;  // word * interval factor
		logic             mul_second; // partial * phase factor
		logic             clamp;      // limit and store new word
		logic             emit;       // load output register
		logic [STS_W-1:0] code;       // status to emit
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic first;   // not yet primed
		logic reject;  // interval out of window
	} sts_t;

endpackage

// ===== sv/cfd_ctrl.sv =====
// ---------------------------------------------------------------------------
// cfd_ctrl: sequencing for capture_frequency_discipline
// Accepts one capture at a time, steps the shared multiplier twice for an
// update, then hands the result to the output register.
// ---------------------------------------------------------------------------
module cfd_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	output logic                m_tvalid,
	input  logic                m_tready,
	input  cfd_pkg::sts_t       sts,
	output cfd_pkg::cmd_t       cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_MUL1  = 3'd1;
	localparam logic [2:0] S_MUL2  = 3'd2;
	localparam logic [2:0] S_CLAMP = 3'd3;
	localparam logic [2:0] S_DONE  = 3'd4;

	logic [2:0]                state_q;
	logic [2:0]                state_d;
	logic [cfd_pkg::STS_W-1:0] code_q;
	logic                      out_valid_q;
	logic                      accept;
	logic                      emit;

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign emit     = (state_q == S_DONE) && (!out_valid_q || m_tready);
	assign m_tvalid = out_valid_q;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (sts.first || sts.reject) state_d = S_DONE;
					else                         state_d = S_MUL1;
				end
			end
			S_MUL1:  state_d = S_MUL2;
			S_MUL2:  state_d = S_CLAMP;
			S_CLAMP: state_d = S_DONE;
			S_DONE: begin
				if (emit) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// State, status code and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			code_q      <= cfd_pkg::ST_PRIMED;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				if (sts.first)       code_q <= cfd_pkg::ST_PRIMED;
				else if (sts.reject) code_q <= cfd_pkg::ST_REJECT;
				else                 code_q <= cfd_pkg::ST_UPDATE;
			end
			if (emit)          out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	// Commands
	always_comb begin
		cmd.load       = accept;
		cmd.mul_first  = (state_q == S_MUL1);
		cmd.mul_second = (state_q == S_MUL2);
		cmd.clamp      = (state_q == S_CLAMP);
		cmd.emit       = emit;
		cmd.code       = code_q;
	end

endmodule

// ===== sv/cfd_datapath.sv =====
// ---------------------------------------------------------------------------
// cfd_datapath: arithmetic and state for capture_frequency_discipline
// Interval and phase factors, one shared multiplier used twice, limit clamp,
// config registers and the output word register.
// ---------------------------------------------------------------------------
module cfd_datapath #(
	parameter int PERIOD_SHIFT = 12
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  cfd_pkg::cmd_t               cmd,
	output cfd_pkg::sts_t               sts,
	input  logic [cfd_pkg::CNT_W-1:0]   capture,
	input  logic                        cfg_we,
	input  logic [cfd_pkg::IDX_W-1:0]   cfg_idx,
	input  logic [cfd_pkg::CFG_W-1:0]   cfg_wdata,
	output logic [cfd_pkg::STS_W-1:0]   out_status,
	output logic [cfd_pkg::FREQ_W-1:0]  out_word
);

	localparam int FW    = cfd_pkg::FREQ_W;
	localparam int CW    = cfd_pkg::CNT_W;
	localparam int SW    = PERIOD_SHIFT + 1;   // factor width, holds up to 1.5P
	localparam int AW    = FW + 1;             // first scaled word
	localparam int RW    = FW + 2;             // second scaled word
	localparam int PW    = AW + SW;            // product width
	localparam int TWO_P = 2 << PERIOD_SHIFT;
	localparam int HALF_P = 1 << (PERIOD_SHIFT - 1);

	logic              primed_q;
	logic [CW-1:0]     prev_q;
	logic [FW-1:0]     freq_q;
	logic [FW-1:0]     high_q;
	logic [FW-1:0]     low_q;
	logic [SW-1:0]     span_q;
	logic [SW-1:0]     phase_q;
	logic [PW-1:0]     prod_q;
	logic [cfd_pkg::STS_W-1:0] status_q;
	logic [FW-1:0]     word_q;

	logic [CW-1:0]     interval;
	logic [SW-1:0]     span;
	logic [SW-1:0]     phase;
	logic [SW-1:0]     low_ext;
	logic [AW-1:0]     mul_a;
	logic [SW-1:0]     mul_b;
	logic [RW-1:0]     scaled;
	logic [RW-1:0]     hi_cut;
	logic [RW-1:0]     clamped;

	// Interval window check, modulo counter width
	assign interval   = capture - prev_q;
	assign sts.first  = !primed_q;
	assign sts.reject = ({1'b0, interval} > (CW+1)'(TWO_P)) ||
	                    ({1'b0, interval} < (CW+1)'(HALF_P));

	// Interval factor 2P - interval, phase factor 2P - L (L lifted by P when low)
	assign span    = SW'(TWO_P) - interval[SW-1:0];
	assign low_ext = {~capture[PERIOD_SHIFT-1], capture[PERIOD_SHIFT-1:0]};
	assign phase   = SW'(TWO_P) - low_ext;

	// Shared multiplier operands
	assign mul_a = cmd.mul_second ? prod_q[PERIOD_SHIFT +: AW] : {1'b0, freq_q};
	assign mul_b = cmd.mul_second ? phase_q : span_q;

	// Clamp: high limit first, low limit second
	assign scaled  = prod_q[PERIOD_SHIFT +: RW];
	assign hi_cut  = (scaled > {2'b00, high_q}) ? {2'b00, high_q} : scaled;
	assign clamped = (hi_cut < {2'b00, low_q}) ? {2'b00, low_q} : hi_cut;

	// Control state and config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			primed_q <= 1'b0;
			prev_q   <= '0;
			freq_q   <= '0;
			high_q   <= '1;
			low_q    <= '0;
		end else begin
			if (cmd.load) begin
				primed_q <= 1'b1;
				prev_q   <= capture;
			end
			if (cmd.clamp) freq_q <= clamped[FW-1:0];
			if (cfg_we) begin
				case (cfg_idx)
					cfd_pkg::REG_START: freq_q <= cfg_wdata[FW-1:0];
					cfd_pkg::REG_HIGH:  high_q <= cfg_wdata[FW-1:0];
					cfd_pkg::REG_LOW:   low_q  <= cfg_wdata[FW-1:0];
					default: ;
				endcase
			end
		end
	end

	// Factor, product and output registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			span_q  <= span;
			phase_q <= phase;
		end
		if (cmd.mul_first || cmd.mul_second) prod_q <= PW'(mul_a) * PW'(mul_b);
		if (cmd.emit) begin
			status_q <= cmd.code;
			word_q   <= freq_q;
		end
	end

	assign out_status = status_q;
	assign out_word   = word_q;

endmodule

// ===== sv/capture_frequency_discipline.sv =====
// ---------------------------------------------------------------------------
// capture_frequency_discipline: frequency word correction from timer captures
// Top level: stream ports, config write channel, controller and datapath.
// ---------------------------------------------------------------------------
// One 16-bit capture word per frame event goes in, one result word comes out:
// tuser carries the status (primed, rejected, updated) and tdata the tuning
// word after the step. The first capture after reset only primes the stored
// capture; a rejected or primed capture goes from accept straight to the done
// state, while an update first takes two passes through one shared multiplier
// and a clamp step. Captures are handled one at a time; a new capture is accepted
// while the previous result still waits in the output register. Writing the
// start frequency register loads the tuning word at once; write config only
// while no capture is in flight.
module capture_frequency_discipline #(
	parameter int PERIOD_SHIFT = 12
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// Input stream
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [15:0]                 s_tdata,   // [15:0] capture_value
	// Output stream
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [31:0]                 m_tdata,   // [31:0] frequency_word
	output logic [1:0]                  m_tuser,   // [1:0] status
	// Config write channel
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [cfd_pkg::IDX_W-1:0]   cfg_index,
	input  logic [cfd_pkg::CFG_W-1:0]   cfg_data
);

	cfd_pkg::cmd_t cmd;
	cfd_pkg::sts_t sts;
	logic          cfg_we;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	cfd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	cfd_datapath #(
		.PERIOD_SHIFT (PERIOD_SHIFT)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.capture    (s_tdata),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_index),
		.cfg_wdata  (cfg_data),
		.out_status (m_tuser),
		.out_word   (m_tdata)
	);

`ifndef SYNTHESIS
	// One capture at a time: intake closes right after an accept
	a_single_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("capture accepted while another is in flight");

	// Status code is always one of the three defined codes
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == cfd_pkg::ST_PRIMED || m_tuser == cfd_pkg::ST_REJECT ||
		              m_tuser == cfd_pkg::ST_UPDATE))
		else $error("undefined status code on output");

	// An updated word respects the high limit unless forced up to the low limit
	a_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == cfd_pkg::ST_UPDATE) |->
		(m_tdata <= u_datapath.high_q) || (m_tdata == u_datapath.low_q))
		else $error("updated word outside limits");
`endif

endmodule
